/* hw/rtl/ped_pkg.sv */
// ---------------------------------------------------------------------------
// ped_pkg
// Shared types, constants and helpers for the particle Euler/drag update pipe
// ---------------------------------------------------------------------------
package ped_pkg;

    localparam int NStage  = 6;
    localparam int PosW    = 32;
    localparam int LifeW   = 24;
    localparam int PhaseW  = 16;
    localparam int DragW   = 16;
    localparam int SpdW    = 24;
    localparam int TimeW   = 16;
    localparam int GravW   = 13;
    localparam int ScaleW  = 16;
    localparam int DampW   = 29;
    localparam int DtW     = DragW + TimeW;
    localparam int VspW    = DtW + ScaleW;
    localparam int GtW     = GravW + TimeW + 1;
    localparam int SpinPW  = SpdW + TimeW + 1;
    localparam int VprodW  = PosW + DampW + 1;
    localparam int StepPW  = PosW + TimeW + 1;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 16;

    localparam logic [DtW:0] OneQ28 = (DtW + 1)'(1) << 28;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STEP_TIME = 2'd0,
        CFG_GRAVITY   = 2'd1,
        CFG_VSCALE    = 2'd2
    } ped_cfg_idx_t;

    typedef struct packed {
        logic        [TimeW-1:0]  step_time;
        logic signed [GravW-1:0]  gravity_accel;
        logic        [ScaleW-1:0] vertical_drag_scale;
    } ped_cfg_t;

    // first field sits in the low bits, so members are listed last-first
    typedef struct packed {
        logic signed [SpdW-1:0]   spin_speed;
        logic        [PhaseW-1:0] spin_angle;
        logic        [DragW-1:0]  drag_rate;
        logic signed [LifeW-1:0]  life_left;
        logic signed [PosW-1:0]   vel_z;
        logic signed [PosW-1:0]   vel_y;
        logic signed [PosW-1:0]   vel_x;
        logic signed [PosW-1:0]   pos_z;
        logic signed [PosW-1:0]   pos_y;
        logic signed [PosW-1:0]   pos_x;
    } ped_item_t;

    typedef struct packed {
        logic        [PhaseW-1:0] new_spin;
        logic signed [LifeW-1:0]  new_life;
        logic signed [PosW-1:0]   new_vz;
        logic signed [PosW-1:0]   new_vy;
        logic signed [PosW-1:0]   new_vx;
        logic signed [PosW-1:0]   new_z;
        logic signed [PosW-1:0]   new_y;
        logic signed [PosW-1:0]   new_x;
    } ped_res_t;

    typedef struct packed {
        logic [NStage-1:0] load;
    } ped_ctrl_t;

    typedef struct packed {
        logic        [DampW-1:0]  lat;
        logic        [DampW-1:0]  vert;
        logic signed [PosW-1:0]   vy;
        logic        [PhaseW-1:0] spin;
        logic                     live;
    } ped_coef_t;

    typedef struct packed {
        logic signed [PosW-1:0]   vx;
        logic signed [PosW-1:0]   vy;
        logic signed [PosW-1:0]   vz;
        logic signed [StepPW-1:0] qx;
        logic signed [StepPW-1:0] qy;
        logic signed [StepPW-1:0] qz;
        logic        [PhaseW-1:0] spin;
        logic                     live;
    } ped_vel_t;

    // one minus loss in Q1.28, clamped at zero
    function automatic logic [DampW-1:0] damp_clamp(input logic [DtW-1:0] loss);
        logic [DtW:0] diff;
        diff = OneQ28 - {1'b0, loss};
        return diff[DtW] ? '0 : diff[DampW-1:0];
    endfunction

    function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW:0] x);
        logic signed [PosW-1:0] r;
        if (x[PosW] != x[PosW-1]) begin
            r = x[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        end else begin
            r = x[PosW-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ped_coef.sv */
// ---------------------------------------------------------------------------
// ped_coef
// Stages 1-3: life update, damping factors, gravity and spin phase
// ---------------------------------------------------------------------------
module ped_coef (
    input  logic                aclk,
    input  ped_pkg::ped_ctrl_t  ctrl,
    input  ped_pkg::ped_cfg_t   cfg,
    input  ped_pkg::ped_item_t  item_in,
    output ped_pkg::ped_item_t  item_out,
    output ped_pkg::ped_coef_t  coef_out
);
    import ped_pkg::*;

    logic signed [LifeW:0]    life_dec;
    logic                     was_alive;
    logic                     live_c;
    ped_item_t                item1_next;
    logic        [DtW-1:0]    dtp_c;
    logic signed [GtW-1:0]    gt_c;
    logic        [VspW-1:0]   vsp_c;
    logic signed [SpinPW-1:0] sprod_c;
    ped_coef_t                coef3_next;

    ped_item_t                item1_reg, item2_reg, item3_reg;
    logic                     live1_reg, live2_reg;
    logic        [DtW-1:0]    dtp1_reg;
    logic signed [GtW-1:0]    gt1_reg;
    logic        [DampW-1:0]  lat2_reg;
    logic        [VspW-1:0]   vsp2_reg;
    logic signed [PosW-1:0]   vy2_reg;
    logic signed [SpinPW-1:0] sprod2_reg;
    ped_coef_t                coef3_reg;

    // stage 1
    always_comb begin
        was_alive  = item_in.life_left > 0;
        life_dec   = (LifeW + 1)'(item_in.life_left) - $signed({1'b0, 8'd0, cfg.step_time});
        live_c     = was_alive && (life_dec > 0);
        item1_next = item_in;
        if (was_alive) begin
            item1_next.life_left = life_dec[LifeW-1:0];
        end
        dtp_c = DtW'(item_in.drag_rate) * DtW'(cfg.step_time);
        gt_c  = $signed(cfg.gravity_accel) * $signed({1'b0, cfg.step_time});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            item1_reg <= item1_next;
            live1_reg <= live_c;
            dtp1_reg  <= dtp_c;
            gt1_reg   <= gt_c;
        end
    end

    // stage 2
    always_comb begin
        vsp_c   = VspW'(dtp1_reg) * VspW'(cfg.vertical_drag_scale);
        sprod_c = $signed(item1_reg.spin_speed) * $signed({1'b0, cfg.step_time});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            item2_reg  <= item1_reg;
            live2_reg  <= live1_reg;
            lat2_reg   <= damp_clamp(dtp1_reg);
            vsp2_reg   <= vsp_c;
            vy2_reg    <= sat32((PosW + 1)'(item1_reg.vel_y) + (PosW + 1)'(gt1_reg));
            sprod2_reg <= sprod_c;
        end
    end

    // stage 3
    always_comb begin
        coef3_next.lat  = lat2_reg;
        coef3_next.vert = damp_clamp(vsp2_reg[VspW-1:ScaleW]);
        coef3_next.vy   = vy2_reg;
        coef3_next.spin = item2_reg.spin_angle + sprod2_reg[PhaseW+TimeW-1:TimeW];
        coef3_next.live = live2_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            item3_reg <= item2_reg;
            coef3_reg <= coef3_next;
        end
    end

    assign item_out = item3_reg;
    assign coef_out = coef3_reg;

endmodule

/* hw/rtl/ped_vel.sv */
// ---------------------------------------------------------------------------
// ped_vel
// Stages 4-5: damped velocities, then velocity times step for integration
// ---------------------------------------------------------------------------
module ped_vel (
    input  logic                aclk,
    input  ped_pkg::ped_ctrl_t  ctrl,
    input  ped_pkg::ped_cfg_t   cfg,
    input  ped_pkg::ped_item_t  item_in,
    input  ped_pkg::ped_coef_t  coef_in,
    output ped_pkg::ped_item_t  item_out,
    output ped_pkg::ped_vel_t   vel_out
);
    import ped_pkg::*;

    logic signed [VprodW-1:0] pvx_c, pvy_c, pvz_c;
    ped_vel_t                 vel5_next;

    ped_item_t                item4_reg, item5_reg;
    logic signed [VprodW-1:0] pvx4_reg, pvy4_reg, pvz4_reg;
    logic        [PhaseW-1:0] spin4_reg;
    logic                     live4_reg;
    ped_vel_t                 vel5_reg;

    // stage 4
    always_comb begin
        pvx_c = $signed(item_in.vel_x) * $signed({1'b0, coef_in.lat});
        pvz_c = $signed(item_in.vel_z) * $signed({1'b0, coef_in.lat});
        pvy_c = $signed(coef_in.vy) * $signed({1'b0, coef_in.vert});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            item4_reg <= item_in;
            pvx4_reg  <= pvx_c;
            pvy4_reg  <= pvy_c;
            pvz4_reg  <= pvz_c;
            spin4_reg <= coef_in.spin;
            live4_reg <= coef_in.live;
        end
    end

    // stage 5
    always_comb begin
        vel5_next.vx   = pvx4_reg[PosW+27:28];
        vel5_next.vy   = pvy4_reg[PosW+27:28];
        vel5_next.vz   = pvz4_reg[PosW+27:28];
        vel5_next.qx   = $signed(vel5_next.vx) * $signed({1'b0, cfg.step_time});
        vel5_next.qy   = $signed(vel5_next.vy) * $signed({1'b0, cfg.step_time});
        vel5_next.qz   = $signed(vel5_next.vz) * $signed({1'b0, cfg.step_time});
        vel5_next.spin = spin4_reg;
        vel5_next.live = live4_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            item5_reg <= item4_reg;
            vel5_reg  <= vel5_next;
        end
    end

    assign item_out = item5_reg;
    assign vel_out  = vel5_reg;

endmodule

/* hw/rtl/ped_pos.sv */
// ---------------------------------------------------------------------------
// ped_pos
// Stage 6: position integration with saturation and result select
// ---------------------------------------------------------------------------
module ped_pos (
    input  logic                aclk,
    input  ped_pkg::ped_ctrl_t  ctrl,
    input  ped_pkg::ped_item_t  item_in,
    input  ped_pkg::ped_vel_t   vel_in,
    output ped_pkg::ped_res_t   res_out,
    output logic                alive_out
);
    import ped_pkg::*;

    ped_res_t res_next;
    ped_res_t res_reg;
    logic     alive_reg;

    always_comb begin
        if (vel_in.live) begin
            res_next.new_x    = sat32((PosW + 1)'(item_in.pos_x)
                                      + (PosW + 1)'($signed(vel_in.qx[PosW+TimeW-1:TimeW])));
            res_next.new_y    = sat32((PosW + 1)'(item_in.pos_y)
                                      + (PosW + 1)'($signed(vel_in.qy[PosW+TimeW-1:TimeW])));
            res_next.new_z    = sat32((PosW + 1)'(item_in.pos_z)
                                      + (PosW + 1)'($signed(vel_in.qz[PosW+TimeW-1:TimeW])));
            res_next.new_vx   = vel_in.vx;
            res_next.new_vy   = vel_in.vy;
            res_next.new_vz   = vel_in.vz;
            res_next.new_spin = vel_in.spin;
        end else begin
            res_next.new_x    = item_in.pos_x;
            res_next.new_y    = item_in.pos_y;
            res_next.new_z    = item_in.pos_z;
            res_next.new_vx   = item_in.vel_x;
            res_next.new_vy   = item_in.vel_y;
            res_next.new_vz   = item_in.vel_z;
            res_next.new_spin = item_in.spin_angle;
        end
        res_next.new_life = item_in.life_left;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[5]) begin
            res_reg   <= res_next;
            alive_reg <= vel_in.live;
        end
    end

    assign res_out   = res_reg;
    assign alive_out = alive_reg;

endmodule

/* hw/rtl/particle_euler_drag_update.sv */
// ---------------------------------------------------------------------------
// particle_euler_drag_update
// One explicit Euler step with drag and gravity for a stream of particles
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------------
//   s_axis   | in  | particle record in tdata
//   m_axis   | out | updated record in tdata, alive flag in tuser
//   cfg      | in  | register index and write data, always ready
//
// six register stages, one beat per cycle sustained while m_axis_tready stays high
// each stage holds a valid bit and advances when it is empty or the next
// stage moves, so bubbles close up during an output stall
// reset clears the valid bits and restores the step, gravity and drag scale
// ---------------------------------------------------------------------------
module particle_euler_drag_update (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, drag_rate,
    // spin_angle, spin_speed
    input  logic [$bits(ped_pkg::ped_item_t)-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // new_x, new_y, new_z, new_vx, new_vy, new_vz, new_life, new_spin
    output logic [$bits(ped_pkg::ped_res_t)-1:0]  m_axis_tdata,
    // alive
    output logic                                 m_axis_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ped_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [ped_pkg::CfgDatW-1:0]          cfg_data
);
    import ped_pkg::*;

    ped_cfg_t          cfg_reg, cfg_next;
    logic [NStage-1:0] valid_reg, valid_next;
    ped_ctrl_t         ctrl;
    ped_item_t         item_s, item_c, item_v;
    ped_coef_t         coef;
    ped_vel_t          vel;
    ped_res_t          res;
    logic              alive;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STEP_TIME: cfg_next.step_time           = cfg_data[TimeW-1:0];
                CFG_GRAVITY:   cfg_next.gravity_accel       = cfg_data[GravW-1:0];
                CFG_VSCALE:    cfg_next.vertical_drag_scale = cfg_data[ScaleW-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        ctrl.load[NStage-1] = !valid_reg[NStage-1] || m_axis_tready;
        for (int k = NStage - 2; k >= 0; k--) begin
            ctrl.load[k] = !valid_reg[k] || ctrl.load[k+1];
        end
        valid_next = valid_reg;
        if (ctrl.load[0]) begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NStage; k++) begin
            if (ctrl.load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_time           <= TimeW'(1092);
            cfg_reg.gravity_accel       <= -GravW'(280);
            cfg_reg.vertical_drag_scale <= ScaleW'(26214);
            valid_reg                   <= '0;
        end else begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    assign item_s = ped_item_t'(s_axis_tdata);

    ped_coef u_coef (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .item_in  (item_s),
        .item_out (item_c),
        .coef_out (coef)
    );

    ped_vel u_vel (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .item_in  (item_c),
        .coef_in  (coef),
        .item_out (item_v),
        .vel_out  (vel)
    );

    ped_pos u_pos (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .item_in   (item_v),
        .vel_in    (vel),
        .res_out   (res),
        .alive_out (alive)
    );

    assign s_axis_tready = ctrl.load[0];
    assign m_axis_tvalid = valid_reg[NStage-1];
    assign m_axis_tdata  = res;
    assign m_axis_tuser  = alive;

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (valid_reg == '1) && !m_axis_tready)
        else $error("input blocked while pipeline has room");

    a_alive_life_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> res.new_life > 0)
        else $error("alive result with non-positive life");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid && (valid_reg == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

/* test/tb_particle_euler_drag_update.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_particle_euler_drag_update
// Self-checking bench for the particle Euler/drag update pipe. Particle
// records go in over the input stream with bursty timing. Results come back
// under random output stalls and are checked field by field against a
// behavioral model of the update step. Register settings change between
// phases, including the extremes and a write to an unused index.
// ---------------------------------------------------------------------------
module tb_particle_euler_drag_update;

    localparam int          CycleLimit   = 400000;
    localparam int          PhaseCount   = 12;
    localparam int          PhaseBeats   = 155;
    localparam longint      UnityDamp    = 64'sd1 << 28;
    localparam logic [ped_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;

    typedef struct packed {
        ped_pkg::ped_res_t rec;
        logic              alive;
    } particle_out_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [$bits(ped_pkg::ped_item_t)-1:0] s_axis_tdata = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [$bits(ped_pkg::ped_res_t)-1:0]  m_axis_tdata;
    logic                                 m_axis_tuser;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [ped_pkg::CfgIdxW-1:0]          cfg_index = '0;
    logic [ped_pkg::CfgDatW-1:0]          cfg_data = '0;

    // register copies, reset values
    logic        [15:0] step_q016   = 16'd1092;
    logic signed [12:0] grav_accel  = -13'sd280;
    logic        [15:0] vdrag_scale = 16'd26214;

    particle_out_t pending_updates[$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    int unsigned   stall_left = 0;
    int unsigned   stall_pct = 0;
    int unsigned   stall_clock = 0;

    particle_euler_drag_update DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CycleLimit) @(posedge aclk);
        $display("FAIL particle_euler_drag_update");
        $finish;
    end

    function automatic logic signed [31:0] clip_q16(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic particle_out_t advance_particle(input ped_pkg::ped_item_t it);
        particle_out_t o;
        longint t, life, drag, spd, dt_prod, lat, vert;
        longint px, py, pz, vx, vy, vz, spin;
        o.rec.new_x    = it.pos_x;
        o.rec.new_y    = it.pos_y;
        o.rec.new_z    = it.pos_z;
        o.rec.new_vx   = it.vel_x;
        o.rec.new_vy   = it.vel_y;
        o.rec.new_vz   = it.vel_z;
        o.rec.new_life = it.life_left;
        o.rec.new_spin = it.spin_angle;
        o.alive        = 1'b0;
        t    = longint'(step_q016);
        life = longint'(it.life_left);
        if (life > 0) begin
            life = life - t;
            o.rec.new_life = life[23:0];
            if (life > 0) begin
                drag = longint'(it.drag_rate);
                spd  = longint'(it.spin_speed);
                px   = longint'(it.pos_x);
                py   = longint'(it.pos_y);
                pz   = longint'(it.pos_z);
                vx   = longint'(it.vel_x);
                vy   = longint'(it.vel_y);
                vz   = longint'(it.vel_z);
                dt_prod = drag * t;
                lat  = UnityDamp - dt_prod;
                vert = UnityDamp - ((dt_prod * longint'(vdrag_scale)) >>> 16);
                if (lat < 0) lat = 0;
                if (vert < 0) vert = 0;
                vx = (vx * lat) >>> 28;
                vz = (vz * lat) >>> 28;
                vy = longint'(clip_q16(vy + longint'(grav_accel) * t));
                vy = (vy * vert) >>> 28;
                px = longint'(clip_q16(px + ((vx * t) >>> 16)));
                py = longint'(clip_q16(py + ((vy * t) >>> 16)));
                pz = longint'(clip_q16(pz + ((vz * t) >>> 16)));
                spin = longint'(it.spin_angle) + ((spd * t) >>> 16);
                o.rec.new_x    = px[31:0];
                o.rec.new_y    = py[31:0];
                o.rec.new_z    = pz[31:0];
                o.rec.new_vx   = vx[31:0];
                o.rec.new_vy   = vy[31:0];
                o.rec.new_vz   = vz[31:0];
                o.rec.new_spin = spin[15:0];
                o.alive        = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3, 4: return $urandom;
            default: return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic ped_pkg::ped_item_t rand_particle();
        ped_pkg::ped_item_t it;
        it.pos_x = rand_q16();
        it.pos_y = rand_q16();
        it.pos_z = rand_q16();
        it.vel_x = rand_q16();
        it.vel_y = rand_q16();
        it.vel_z = rand_q16();
        case ($urandom_range(0, 9))
            0:       it.life_left = 24'(-int'($urandom_range(0, 24'h800000)));
            1:       it.life_left = 24'($urandom);
            2:       it.life_left = 24'($urandom_range(1, (step_q016 == 0) ? 1 : step_q016));
            default: it.life_left = 24'($urandom_range(int'(step_q016) + 1, 24'h7FFFFF));
        endcase
        case ($urandom_range(0, 9))
            0:       it.drag_rate = '0;
            1:       it.drag_rate = 16'hFFFF;
            2, 3:    it.drag_rate = 16'($urandom);
            default: it.drag_rate = 16'($urandom_range(0, 4096));
        endcase
        it.spin_angle = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       it.spin_speed = 24'sh7FFFFF;
            1:       it.spin_speed = 24'sh800000;
            default: it.spin_speed = 24'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_particle(input ped_pkg::ped_item_t it);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tdata  <= it;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_updates.push_back(advance_particle(it));
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_updates.size() != 0) @(negedge aclk);
        repeat (ped_pkg::NStage + 4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ped_pkg::CfgIdxW-1:0] idx,
                             input logic [ped_pkg::CfgDatW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            ped_pkg::CFG_STEP_TIME: step_q016   = data;
            ped_pkg::CFG_GRAVITY:   grav_accel  = data[12:0];
            ped_pkg::CFG_VSCALE:    vdrag_scale = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // upper bits of the gravity word carry junk that must be dropped
    task automatic set_config(input logic [15:0] step, input logic signed [12:0] grav,
                              input logic [15:0] vscale, input bit spare_write);
        wait_drained();
        write_reg(ped_pkg::CFG_STEP_TIME, step);
        write_reg(ped_pkg::CFG_GRAVITY, {3'($urandom), grav});
        write_reg(ped_pkg::CFG_VSCALE, vscale);
        if (spare_write) write_reg(CfgIdxSpare, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // output stall pattern; the stall rate is redrawn at random from 0, 15 and 50 percent
    always @(negedge aclk) begin
        stall_clock++;
        if (stall_clock % 300 == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 50;
                default: stall_pct = 15;
            endcase
        end
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 10);
        end
    end

    always @(posedge aclk) begin
        particle_out_t     want;
        ped_pkg::ped_res_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_updates.size() == 0) begin
                $error("result beat with no particle outstanding");
                mismatch_count++;
            end else begin
                want = pending_updates.pop_front();
                check_field("new_x", want.rec.new_x, got.new_x);
                check_field("new_y", want.rec.new_y, got.new_y);
                check_field("new_z", want.rec.new_z, got.new_z);
                check_field("new_vx", want.rec.new_vx, got.new_vx);
                check_field("new_vy", want.rec.new_vy, got.new_vy);
                check_field("new_vz", want.rec.new_vz, got.new_vz);
                check_field("new_life", 32'(want.rec.new_life), 32'(got.new_life));
                check_field("new_spin", 32'(want.rec.new_spin), 32'(got.new_spin));
                check_field("alive", 32'(want.alive), 32'(m_axis_tuser));
            end
        end
    end

    task automatic test_reset_values();
        repeat (3) send_particle(rand_particle());
    endtask

    task automatic test_dead_passthrough();
        ped_pkg::ped_item_t it;
        it = rand_particle();
        it.life_left = '0;
        send_particle(it);
        it = rand_particle();
        it.life_left = -24'sd1;
        send_particle(it);
        it = rand_particle();
        it.life_left = 24'sh800000;
        send_particle(it);
    endtask

    task automatic test_dying_boundary();
        ped_pkg::ped_item_t it;
        it = rand_particle();
        it.life_left = 24'sd1;
        send_particle(it);
        it = rand_particle();
        it.life_left = 24'(step_q016);
        send_particle(it);
        it = rand_particle();
        it.life_left = 24'(step_q016) + 24'd1;
        send_particle(it);
    endtask

    task automatic test_zero_step();
        ped_pkg::ped_item_t it;
        set_config(16'd0, 13'($urandom), 16'($urandom), 1'b0);
        it = rand_particle();
        it.life_left = 24'sd1;
        send_particle(it);
        it = rand_particle();
        it.life_left = 24'sh7FFFFF;
        it.drag_rate = 16'hFFFF;
        send_particle(it);
        it = rand_particle();
        it.life_left = '0;
        send_particle(it);
    endtask

    task automatic test_saturation_and_clamp();
        ped_pkg::ped_item_t it;
        set_config(16'hFFFF, 13'sd4095, 16'd0, 1'b0);
        it = rand_particle();
        it.life_left = 24'sh7FFFFF;
        it.drag_rate = '0;
        it.pos_x = 32'sh7FFFFFFF;
        it.vel_x = 32'sh7FFFFFFF;
        it.pos_y = 32'sh80000000;
        it.vel_y = 32'sh7FFFFFFF;
        it.pos_z = 32'sh80000000;
        it.vel_z = 32'sh80000000;
        send_particle(it);
        it.pos_x = 32'sh80000000;
        it.vel_x = 32'sh80000000;
        it.pos_y = 32'sh7FFFFFFF;
        it.vel_y = 32'sh80000000;
        it.pos_z = 32'sh7FFFFFFF;
        it.vel_z = 32'sh7FFFFFFF;
        it.spin_angle = 16'hFFFF;
        it.spin_speed = 24'sh7FFFFF;
        send_particle(it);
        it.drag_rate = 16'hFFFF;
        it.spin_speed = 24'sh800000;
        send_particle(it);
        set_config(16'hFFFF, -13'sd4096, 16'hFFFF, 1'b1);
        it.drag_rate = '0;
        it.vel_y = 32'sh80000000;
        send_particle(it);
        it.drag_rate = 16'hFFFF;
        send_particle(it);
        it = rand_particle();
        it.life_left = 24'sh7FFFFF;
        it.drag_rate = 16'd4096;
        send_particle(it);
    endtask

    task automatic test_random_phases();
        logic        [15:0] step;
        logic signed [12:0] grav;
        logic        [15:0] vscale;
        for (int p = 0; p < PhaseCount; p++) begin
            case (p)
                0: begin
                    step = 16'd0;
                    grav = 13'($urandom);
                    vscale = 16'($urandom);
                end
                1: begin
                    step = 16'hFFFF;
                    grav = -13'sd4096;
                    vscale = 16'hFFFF;
                end
                2: begin
                    step = 16'd1;
                    grav = 13'sd4095;
                    vscale = 16'd0;
                end
                3: begin
                    step = 16'd1092;
                    grav = '0;
                    vscale = 16'd26214;
                end
                default: begin
                    step = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(1, 4369));
                    grav = 13'($urandom);
                    vscale = 16'($urandom);
                end
            endcase
            set_config(step, grav, vscale, p[0]);
            repeat (PhaseBeats) send_particle(rand_particle());
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_dead_passthrough();
        test_dying_boundary();
        test_zero_step();
        test_saturation_and_clamp();
        test_random_phases();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASS particle_euler_drag_update");
        end else begin
            $display("FAIL particle_euler_drag_update");
        end
        $finish;
    end

endmodule
